// ===== hdl/rss_pkg.sv =====
`timescale 1ns / 1ps

package rss_pkg;

   localparam int CAPACITY   = 256;
   localparam int KEY_W      = 32;
   localparam int RANK_W     = 8;
   localparam int STATUS_W   = 2;
   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int POS_CMP_W  = (CNT_W > RANK_W) ? CNT_W : RANK_W;
   localparam int RANK_ACC_W = (IDX_W > RANK_W) ? IDX_W : RANK_W;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

   typedef struct packed {
      logic                    op;
      logic signed [KEY_W-1:0] key;
      logic [RANK_W-1:0]       rank_to_remove;
   } rss_req_type;

   typedef struct packed {
      logic [RANK_W-1:0]   rank;
      logic [STATUS_W-1:0] status;
   } rss_rsp_type;

   typedef struct packed {
      logic                    compare;
      logic                    insert;
      logic                    remove;
      logic signed [KEY_W-1:0] key;
      logic [RANK_W-1:0]       pos;
   } rss_cell_ctrl_type;

   typedef enum logic [1:0] {
      RSS_IDLE,
      RSS_COMPARE,
      RSS_APPLY
   } rss_state_type;

endpackage

// ===== hdl/rss_cell.sv =====
`timescale 1ns / 1ps

module rss_cell import rss_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  rss_cell_ctrl_type       ctrl,
   input  logic [IDX_W-1:0]        cell_index,
   input  logic signed [KEY_W-1:0] prev_key,
   input  logic                    prev_valid,
   input  logic                    prev_gt,
   input  logic signed [KEY_W-1:0] next_key,
   input  logic                    next_valid,
   output logic signed [KEY_W-1:0] key,
   output logic                    valid,
   output logic                    gt,
   output logic                    eq
);

   logic signed [KEY_W-1:0] key_ff, key_in;
   logic                    valid_ff, valid_in;
   logic                    gt_ff, gt_in;
   logic                    eq_ff, eq_in;
   logic                    at_or_after_pos;

   assign at_or_after_pos = POS_CMP_W'(cell_index) >= POS_CMP_W'(ctrl.pos);

   always_comb begin
      key_in   = key_ff;
      valid_in = valid_ff;
      gt_in    = gt_ff;
      eq_in    = eq_ff;
      if (ctrl.compare) begin
         gt_in = valid_ff && (key_ff > ctrl.key);
         eq_in = valid_ff && (key_ff == ctrl.key);
      end
      if (ctrl.insert && !gt_ff) begin
         if (prev_gt) begin
            key_in   = ctrl.key;
            valid_in = 1'b1;
         end else begin
            key_in   = prev_key;
            valid_in = prev_valid;
         end
      end
      if (ctrl.remove && at_or_after_pos) begin
         key_in   = next_key;
         valid_in = next_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         gt_ff    <= 1'b0;
         eq_ff    <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         gt_ff    <= gt_in;
         eq_ff    <= eq_in;
      end
      key_ff <= key_in;
   end

   assign key   = key_ff;
   assign valid = valid_ff;
   assign gt    = gt_ff;
   assign eq    = eq_ff;

endmodule

// ===== hdl/ranked_sorted_set.sv =====
`timescale 1ns / 1ps

// The set is held in a row of cells in descending key order, each cell holding one key and
// a valid bit. A transaction is taken in the idle state, every cell compares its key with the
// new key in the compare state, and in the apply state the row shifts by one place to open or
// close a gap while the rank is encoded from the boundary cell; no new transaction is taken
// until the apply state ends. An insert transaction yields one result; a remove transaction
// yields none. The apply state waits while an earlier result is held on a stalled output.

module ranked_sorted_set import rss_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  rss_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rss_rsp_type rsp_payload
);

   rss_state_type state_ff, state_in;

   rss_req_type       req_ff;
   rss_rsp_type       rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   rss_cell_ctrl_type ctrl;

   logic                    compare_en;
   logic                    apply_en;
   logic                    out_free;
   logic                    full;
   logic                    dup;
   logic                    pos_ok;
   logic                    do_insert;
   logic                    do_remove;
   logic [RANK_ACC_W-1:0]   rank_acc;

   logic signed [KEY_W-1:0] cell_key   [CAPACITY];
   logic                    cell_valid [CAPACITY];
   logic                    cell_gt    [CAPACITY];
   logic                    cell_eq    [CAPACITY];
   logic                    left_gt    [CAPACITY];

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         RSS_IDLE: begin
            if (req_valid) begin
               state_in = RSS_COMPARE;
            end
         end
         RSS_COMPARE: begin
            state_in = RSS_APPLY;
         end
         RSS_APPLY: begin
            if (out_free) begin
               state_in = RSS_IDLE;
            end
         end
         default: begin
            state_in = RSS_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall  = 1'b1;
      compare_en = 1'b0;
      apply_en   = 1'b0;
      case (state_ff)
         RSS_IDLE: begin
            req_stall = reset;
         end
         RSS_COMPARE: begin
            compare_en = 1'b1;
         end
         RSS_APPLY: begin
            apply_en = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_comb begin
      dup      = 1'b0;
      rank_acc = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         dup = dup | cell_eq[i];
         if (left_gt[i] && !cell_gt[i]) begin
            rank_acc = rank_acc | RANK_ACC_W'(i);
         end
      end
   end

   assign full      = count_ff == CNT_W'(CAPACITY);
   assign pos_ok    = POS_CMP_W'(req_ff.rank_to_remove) < POS_CMP_W'(count_ff);
   assign do_insert = apply_en && (req_ff.op == OP_INSERT) && !dup && !full;
   assign do_remove = apply_en && (req_ff.op == OP_REMOVE) && pos_ok;

   assign ctrl.compare = compare_en;
   assign ctrl.insert  = do_insert;
   assign ctrl.remove  = do_remove;
   assign ctrl.key     = req_ff.key;
   assign ctrl.pos     = req_ff.rank_to_remove;

   always_comb begin
      count_in = count_ff;
      if (do_insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_remove) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (apply_en && (req_ff.op == OP_INSERT)) begin
         rsp_valid_in = 1'b1;
         if (dup) begin
            rsp_in.rank   = rank_acc[RANK_W-1:0];
            rsp_in.status = ST_DUPLICATE;
         end else if (full) begin
            rsp_in.rank   = '0;
            rsp_in.status = ST_FULL;
         end else begin
            rsp_in.rank   = rank_acc[RANK_W-1:0];
            rsp_in.status = ST_INSERTED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= RSS_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
      if (req_valid && !req_stall) begin
         req_ff <= req_payload;
      end
      rsp_ff <= rsp_in;
   end

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : gen_cell
         logic signed [KEY_W-1:0] prev_key;
         logic                    prev_valid;
         logic signed [KEY_W-1:0] next_key;
         logic                    next_valid;

         if (g == 0) begin : gen_first
            assign prev_key   = req_ff.key;
            assign prev_valid = 1'b0;
            assign left_gt[g] = 1'b1;
         end else begin : gen_inner
            assign prev_key   = cell_key[g-1];
            assign prev_valid = cell_valid[g-1];
            assign left_gt[g] = cell_gt[g-1];
         end

         if (g == CAPACITY - 1) begin : gen_last
            assign next_key   = cell_key[g];
            assign next_valid = 1'b0;
         end else begin : gen_body
            assign next_key   = cell_key[g+1];
            assign next_valid = cell_valid[g+1];
         end

         rss_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .cell_index (IDX_W'(g)),
            .prev_key   (prev_key),
            .prev_valid (prev_valid),
            .prev_gt    (left_gt[g]),
            .next_key   (next_key),
            .next_valid (next_valid),
            .key        (cell_key[g]),
            .valid      (cell_valid[g]),
            .gt         (cell_gt[g]),
            .eq         (cell_eq[g])
         );
      end
   endgenerate

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import rss_pkg::*;

   localparam int TARGET_ITEMS = 900;
   localparam int QUIET_TAIL   = 100;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      rss_req_type item;
      logic        given_valid;
      rss_rsp_type given;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   rss_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rss_rsp_type rsp_payload;

   logic signed [KEY_W-1:0] model_keys [CAPACITY];
   int                      model_count = 0;
   rss_rsp_type             expected_rsps [$];
   directed_row_type        directed_rows [$];

   int  fault_count = 0;
   int  mismatch_count = 0;
   int  items_sent = 0;
   int  results_checked = 0;
   int  inserts_sent = 0;
   int  removes_sent = 0;
   int  removes_ignored = 0;
   int  duplicates_seen = 0;
   int  full_refusals = 0;
   int  peak_count = 0;
   int  src_level = 0;
   int  sink_level = 0;
   int  stall_left = 0;
   int  sink_cycles = 0;
   bit  quiet = 1'b0;

   ranked_sorted_set i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #2 clock = ~clock;

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   task automatic update_rank_model(input rss_req_type item, output bit makes_result,
                                    output rss_rsp_type predicted);
      logic signed [KEY_W-1:0] k;
      int                      r;
      int                      i;
      k = item.key;
      r = 0;
      makes_result = 1'b0;
      predicted = '0;
      if (item.op == OP_INSERT) begin
         makes_result = 1'b1;
         inserts_sent++;
         while (r < model_count && model_keys[r] > k) r++;
         predicted.rank = r[RANK_W-1:0];
         if (r < model_count && model_keys[r] == k) begin
            predicted.status = ST_DUPLICATE;
            duplicates_seen++;
         end else if (model_count >= CAPACITY) begin
            predicted.rank = '0;
            predicted.status = ST_FULL;
            full_refusals++;
         end else begin
            for (i = model_count; i > r; i--) model_keys[i] = model_keys[i-1];
            model_keys[r] = k;
            model_count++;
            predicted.status = ST_INSERTED;
            if (model_count > peak_count) peak_count = model_count;
         end
      end else begin
         removes_sent++;
         if (int'(item.rank_to_remove) < model_count) begin
            for (i = int'(item.rank_to_remove); i + 1 < model_count; i++) begin
               model_keys[i] = model_keys[i+1];
            end
            model_count--;
         end else begin
            removes_ignored++;
         end
      end
   endtask

   task automatic submit(input rss_req_type item, input bit use_given, input rss_rsp_type given);
      rss_rsp_type predicted;
      bit          makes_result;
      update_rank_model(item, makes_result, predicted);
      if (makes_result) expected_rsps.push_back(use_given ? given : predicted);
      if (items_sent % 40 == 0) src_level = $urandom_range(0, 2);
      if (items_sent >= TARGET_ITEMS - QUIET_TAIL) quiet = 1'b1;
      if (!quiet && src_level != 0 && $urandom_range(0, 99) < src_level * 12) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   function automatic rss_req_type make_item(input logic op, input logic [KEY_W-1:0] key,
                                             input logic [RANK_W-1:0] pos);
      rss_req_type item;
      item.op = op;
      item.key = key;
      item.rank_to_remove = pos;
      return item;
   endfunction

   function automatic logic [KEY_W-1:0] pick_key(input int pool);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 12 && model_count > 0) return model_keys[$urandom_range(0, model_count - 1)];
      if (roll < 18) begin
         case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            default: return 32'hffff_ffff;
         endcase
      end
      if (pool != 0) return $urandom_range(0, 2 * pool) - pool;
      return $urandom;
   endfunction

   function automatic logic [RANK_W-1:0] pick_pos(input bit in_range);
      if (in_range && model_count > 0) return RANK_W'($urandom_range(0, model_count - 1));
      return RANK_W'($urandom_range(0, 255));
   endfunction

   task automatic add_row(input logic op, input logic [KEY_W-1:0] key,
                          input logic [RANK_W-1:0] pos, input bit given_valid,
                          input logic [RANK_W-1:0] rank, input logic [STATUS_W-1:0] status);
      directed_row_type row;
      row.item = make_item(op, key, pos);
      row.given_valid = given_valid;
      row.given.rank = rank;
      row.given.status = status;
      directed_rows.push_back(row);
   endtask

   function automatic void report_fault(input string what, input rss_rsp_type want,
                                        input rss_rsp_type got);
      fault_count++;
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("%0t: %s: expected rank %0d status %0d, got rank %0d status %0d",
                  $realtime, what, want.rank, want.status, got.rank, got.status);
      end
   endfunction

   always @(posedge clock) begin
      rss_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               report_fault("unexpected result", '0, rsp_payload);
            end else begin
               want = expected_rsps.pop_front();
               results_checked++;
               if (rsp_payload.rank !== want.rank || rsp_payload.status !== want.status) begin
                  report_fault("result mismatch", want, rsp_payload);
               end
            end
         end
         sink_cycles++;
         if (sink_cycles % 150 == 0) sink_level = $urandom_range(0, 2);
         if (stall_left > 0) begin
            stall_left--;
         end else if (!quiet && sink_level != 0 && $urandom_range(0, 99) < sink_level * 12) begin
            stall_left = $urandom_range(1, 14);
         end
         if (quiet) stall_left = 0;
         rsp_stall <= (stall_left > 0);
      end
   end

   initial begin
      int          roll;
      int          n;
      rss_rsp_type none;
      none = '0;

      add_row(OP_REMOVE, 32'hdead_beef, 8'd0,   0, 8'd0, ST_INSERTED);
      add_row(OP_INSERT, 32'h0000_0000, 8'hff,  1, 8'd0, ST_INSERTED);
      add_row(OP_INSERT, 32'h0000_0000, 8'h00,  1, 8'd0, ST_DUPLICATE);
      add_row(OP_INSERT, 32'h7fff_ffff, 8'h5a,  1, 8'd0, ST_INSERTED);
      add_row(OP_INSERT, 32'h8000_0000, 8'ha5,  1, 8'd2, ST_INSERTED);
      add_row(OP_INSERT, 32'h8000_0000, 8'h00,  1, 8'd2, ST_DUPLICATE);
      add_row(OP_INSERT, 32'hffff_ffff, 8'h00,  0, 8'd0, ST_INSERTED);
      add_row(OP_INSERT, 32'h0000_0001, 8'h00,  0, 8'd0, ST_INSERTED);
      add_row(OP_INSERT, 32'h7fff_ffff, 8'h00,  1, 8'd0, ST_DUPLICATE);
      add_row(OP_INSERT, 32'h7fff_fffe, 8'h00,  0, 8'd0, ST_INSERTED);
      add_row(OP_INSERT, 32'h8000_0001, 8'h00,  0, 8'd0, ST_INSERTED);
      add_row(OP_REMOVE, 32'h0000_0000, 8'd255, 0, 8'd0, ST_INSERTED);
      add_row(OP_REMOVE, 32'hffff_ffff, 8'd7,   0, 8'd0, ST_INSERTED);
      add_row(OP_REMOVE, 32'h1234_5678, 8'd6,   0, 8'd0, ST_INSERTED);
      add_row(OP_INSERT, 32'h8000_0000, 8'h00,  0, 8'd0, ST_INSERTED);
      add_row(OP_REMOVE, 32'h0000_0000, 8'd0,   0, 8'd0, ST_INSERTED);
      add_row(OP_INSERT, 32'h5555_5555, 8'h00,  0, 8'd0, ST_INSERTED);
      add_row(OP_INSERT, 32'haaaa_aaaa, 8'h00,  0, 8'd0, ST_INSERTED);
      add_row(OP_REMOVE, 32'hffff_ffff, 8'd3,   0, 8'd0, ST_INSERTED);
      add_row(OP_INSERT, 32'h0000_0001, 8'h00,  0, 8'd0, ST_INSERTED);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         submit(directed_rows[i].item, directed_rows[i].given_valid, directed_rows[i].given);
      end

      // Fill the store to capacity, mostly with fresh keys.
      while (model_count < CAPACITY) begin
         if ($urandom_range(0, 99) < 92) submit(make_item(OP_INSERT, pick_key(0), pick_pos(0)),
                                                0, none);
         else submit(make_item(OP_REMOVE, $urandom, pick_pos(0)), 0, none);
      end

      // Hammer the full store with duplicates, new keys and the odd removal.
      for (n = 0; n < 24; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 40) begin
            submit(make_item(OP_INSERT, model_keys[$urandom_range(0, model_count - 1)],
                             pick_pos(0)), 0, none);
         end else if (roll < 85) begin
            submit(make_item(OP_INSERT, pick_key(0), pick_pos(0)), 0, none);
         end else begin
            submit(make_item(OP_REMOVE, $urandom, pick_pos(1)), 0, none);
         end
      end

      while (model_count > 4) begin
         roll = $urandom_range(0, 99);
         if (roll < 88) submit(make_item(OP_REMOVE, $urandom, pick_pos(1)), 0, none);
         else if (roll < 94) submit(make_item(OP_REMOVE, $urandom, pick_pos(0)), 0, none);
         else submit(make_item(OP_INSERT, pick_key(0), pick_pos(0)), 0, none);
      end

      // A small key range keeps duplicates and out-of-range removals frequent.
      while (items_sent < TARGET_ITEMS) begin
         if ($urandom_range(0, 99) < 55) begin
            submit(make_item(OP_INSERT, pick_key(12), pick_pos(0)), 0, none);
         end else begin
            submit(make_item(OP_REMOVE, $urandom, RANK_W'($urandom_range(0, 15))), 0, none);
         end
      end

      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d transactions (%0d inserts, %0d removes, %0d removes out of range).",
               items_sent, inserts_sent, removes_sent, removes_ignored);
      $display("Checked %0d results: %0d duplicates, %0d refused when full, peak size %0d.",
               results_checked, duplicates_seen, full_refusals, peak_count);
      if (fault_count == 0) begin
         $display("tb: success");
      end else begin
         $display("%0d faults found.", fault_count);
         $display("tb: failure");
      end
      $finish;
   end

endmodule
